>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the kinematics block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

>>> rtl/core/dek_pkg.sv
// Types and constants for the DIS event kinematics block.
// No dependencies.
package dek_pkg;
   localparam int unsigned OutWidth = 64;
   localparam int unsigned MassWidth = 63;
   localparam int unsigned WideWidth = 128;

   typedef struct packed {
      logic signed [OutWidth-1:0] q_squared;
      logic signed [OutWidth-1:0] bjorken_x;
      logic [MassWidth-1:0] hadronic_mass;
      logic signed [OutWidth-1:0] inelasticity;
      logic x_denominator_zero;
      logic w_nonphysical;
      logic y_denominator_zero;
      logic saturated;
   } rsp_type;
endpackage

>>> rtl/core/dek_if.sv
// Valid/ready channel interface carrying a payload of parameter type.
// Depends on nothing; the payload type is given at instantiation.
interface dek_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/dek_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// Depends on dek_pkg for the wide width.
module dek_div #(
   parameter int unsigned Steps = 160,
   parameter type tag_type = logic
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [dek_pkg::WideWidth-1:0] in_num,
   input  logic [dek_pkg::WideWidth-1:0] in_den,
   input  tag_type in_tag,
   output logic out_valid,
   output logic [dek_pkg::OutWidth-1:0] out_quot,
   output logic out_ovf,
   output tag_type out_tag
);
   import dek_pkg::*;
   localparam int unsigned RW = WideWidth + 1;
   logic [RW-1:0] rem_ff [Steps+1];
   logic [WideWidth-1:0] num_ff [Steps+1];
   logic [WideWidth-1:0] den_ff [Steps+1];
   logic [OutWidth-1:0] quo_ff [Steps+1];
   logic ovf_ff [Steps+1];
   logic vld_ff [Steps+1];
   tag_type tag_ff [Steps+1];

   always_comb begin
      rem_ff[0] = '0;
      num_ff[0] = in_num;
      den_ff[0] = in_den;
      quo_ff[0] = '0;
      ovf_ff[0] = 1'b0;
      vld_ff[0] = in_valid;
      tag_ff[0] = in_tag;
   end

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [RW-1:0] sh_in;
      logic ge_in;
      assign sh_in = {rem_ff[k][RW-2:0], num_ff[k][WideWidth-1]};
      assign ge_in = sh_in >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (advance) begin
            rem_ff[k+1] <= ge_in ? sh_in - {1'b0, den_ff[k]} : sh_in;
            num_ff[k+1] <= {num_ff[k][WideWidth-2:0], 1'b0};
            den_ff[k+1] <= den_ff[k];
            quo_ff[k+1] <= {quo_ff[k][OutWidth-2:0], ge_in};
            ovf_ff[k+1] <= ovf_ff[k] | quo_ff[k][OutWidth-1];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[Steps];
   assign out_quot = quo_ff[Steps];
   assign out_ovf = ovf_ff[Steps];
   assign out_tag = tag_ff[Steps];
endmodule

>>> rtl/core/dis_event_kinematics_top.sv
// Top level of the DIS event kinematics block (electron method).
// Depends on dek_pkg, dek_if, dek_div and assert_macros.svh.
//
//   channel  direction  payload
//   req      in         twelve IN_WIDTH four-vector components
//   rsp      out        Q2, x, W, y and four flags
//
// One request can enter every cycle while the pipeline is not frozen; a request
// passes through four arithmetic stages, the 63-stage square root, the 160-stage
// dividers for x and y working side by side, and the output register. A result
// waiting on rsp freezes the whole pipeline, so req_ready drops in the same
// cycle. Reset is synchronous and clears only the valid bits.
`include "assert_macros.svh"
module dis_event_kinematics_top #(
   parameter int unsigned IN_WIDTH = 32,
   parameter int unsigned IN_FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic signed [IN_WIDTH-1:0] req_lep_in_px,
   input logic signed [IN_WIDTH-1:0] req_lep_in_py,
   input logic signed [IN_WIDTH-1:0] req_lep_in_pz,
   input logic signed [IN_WIDTH-1:0] req_lep_in_e,
   input logic signed [IN_WIDTH-1:0] req_lep_out_px,
   input logic signed [IN_WIDTH-1:0] req_lep_out_py,
   input logic signed [IN_WIDTH-1:0] req_lep_out_pz,
   input logic signed [IN_WIDTH-1:0] req_lep_out_e,
   input logic signed [IN_WIDTH-1:0] req_had_in_px,
   input logic signed [IN_WIDTH-1:0] req_had_in_py,
   input logic signed [IN_WIDTH-1:0] req_had_in_pz,
   input logic signed [IN_WIDTH-1:0] req_had_in_e,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic signed [63:0] rsp_q_squared,
   output logic signed [63:0] rsp_bjorken_x,
   output logic [62:0] rsp_hadronic_mass,
   output logic signed [63:0] rsp_inelasticity,
   output logic rsp_x_denominator_zero,
   output logic rsp_w_nonphysical,
   output logic rsp_y_denominator_zero,
   output logic rsp_saturated
);
   import dek_pkg::*;
   // Two extra bits so that P + l - l' cannot overflow.
   localparam int unsigned DW = IN_WIDTH + 2;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned WW = WideWidth;
   localparam int Shift = 2 * IN_FRAC_BITS - 32;
   localparam int unsigned Up = 64 - 2 * IN_FRAC_BITS;
   localparam int unsigned SqSteps = 63;
   localparam int unsigned DivSteps = 160;

   typedef logic signed [DW-1:0] comp_type;
   typedef logic signed [WW-1:0] wide_type;
   typedef struct packed {
      logic xz;
      logic wn;
      logic yz;
      logic xneg;
      logic yneg;
      logic signed [OutWidth-1:0] q2;
      logic q2sat;
      logic [OutWidth-1:0] w;
      logic wsat;
   } side_type;

   // Input channel wraps the ports in the interface.
   typedef struct packed { logic signed [12*IN_WIDTH-1:0] v; } req_type;
   dek_if #(.payload_type(req_type)) req_ch (.clock(clock));
   dek_if #(.payload_type(rsp_type)) rsp_ch (.clock(clock));
   assign req_ch.valid = req_valid;
   assign req_ready = req_ch.ready;
   assign req_ch.data.v = {req_lep_in_px, req_lep_in_py, req_lep_in_pz, req_lep_in_e,
      req_lep_out_px, req_lep_out_py, req_lep_out_pz, req_lep_out_e,
      req_had_in_px, req_had_in_py, req_had_in_pz, req_had_in_e};
   assign rsp_valid = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign rsp_q_squared = rsp_ch.data.q_squared;
   assign rsp_bjorken_x = rsp_ch.data.bjorken_x;
   assign rsp_hadronic_mass = rsp_ch.data.hadronic_mass;
   assign rsp_inelasticity = rsp_ch.data.inelasticity;
   assign rsp_x_denominator_zero = rsp_ch.data.x_denominator_zero;
   assign rsp_w_nonphysical = rsp_ch.data.w_nonphysical;
   assign rsp_y_denominator_zero = rsp_ch.data.y_denominator_zero;
   assign rsp_saturated = rsp_ch.data.saturated;

   logic out_vld_ff;
   rsp_type out_ff;
   logic advance;
   assign advance = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   function automatic comp_type comp(input logic [12*IN_WIDTH-1:0] v, input int idx);
      logic signed [IN_WIDTH-1:0] c;
      c = v[(11-idx)*IN_WIDTH +: IN_WIDTH];
      return comp_type'(c);
   endfunction

   // Stage 1: q = l - l', s = P + q, keep l and P.
   logic v1_ff;
   comp_type l_ff [4], p_ff [4], q_ff [4], s_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_ch.valid;
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            // Components arrive as px, py, pz, e; index 3 is energy.
            l_ff[i] <= comp(req_ch.data.v, i);
            p_ff[i] <= comp(req_ch.data.v, 8 + i);
            q_ff[i] <= comp(req_ch.data.v, i) - comp(req_ch.data.v, 4 + i);
            s_ff[i] <= comp(req_ch.data.v, 8 + i) + comp(req_ch.data.v, i)
               - comp(req_ch.data.v, 4 + i);
         end
      end
   end

   // Stage 2: sixteen products.
   logic v2_ff;
   logic signed [PW-1:0] mqq_ff [4], mqp_ff [4], mss_ff [4], mlp_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            mqq_ff[i] <= q_ff[i] * q_ff[i];
            mqp_ff[i] <= q_ff[i] * p_ff[i];
            mss_ff[i] <= s_ff[i] * s_ff[i];
            mlp_ff[i] <= l_ff[i] * p_ff[i];
         end
      end
   end

   // Stage 3: Minkowski sums.
   logic v3_ff;
   wide_type q2_ff, qp_ff, w2_ff, lpd_ff;
   function automatic wide_type mink(input logic signed [PW-1:0] m [4]);
      return wide_type'(m[3]) - wide_type'(m[0]) - wide_type'(m[1]) - wide_type'(m[2]);
   endfunction
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         q2_ff <= -mink(mqq_ff);
         qp_ff <= mink(mqp_ff);
         w2_ff <= mink(mss_ff);
         lpd_ff <= mink(mlp_ff);
      end
   end

   // Stage 4: Q2 scaling and clamp, flags, magnitudes for division, square-root operand.
   logic v4_ff;
   side_type s4_ff;
   logic [WW-1:0] xn_ff, xd_ff, yn_ff, yd_ff, wv_ff;
   wide_type q2s_in;
   always_comb begin
      if (Shift > 0) q2s_in = (q2_ff + (wide_type'(1) <<< (Shift > 0 ? Shift - 1 : 0)))
         >>> (Shift > 0 ? Shift : 0);
      else q2s_in = q2_ff <<< (Shift < 0 ? -Shift : 0);
   end
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         s4_ff.xz <= qp_ff == '0;
         s4_ff.yz <= lpd_ff == '0;
         s4_ff.wn <= w2_ff[WW-1] || w2_ff == '0;
         s4_ff.xneg <= q2_ff[WW-1] != qp_ff[WW-1];
         s4_ff.yneg <= qp_ff[WW-1] != lpd_ff[WW-1];
         s4_ff.q2sat <= q2s_in[WW-1:OutWidth-1] != {(WW-OutWidth+1){q2s_in[OutWidth-1]}};
         s4_ff.q2 <= (q2s_in[WW-1:OutWidth-1] == {(WW-OutWidth+1){q2s_in[OutWidth-1]}})
            ? q2s_in[OutWidth-1:0]
            : (q2s_in[WW-1] ? {1'b1, {(OutWidth-1){1'b0}}} : {1'b0, {(OutWidth-1){1'b1}}});
         s4_ff.w <= '0;
         s4_ff.wsat <= (w2_ff >> (126 - Up)) != '0;
         xn_ff <= q2_ff[WW-1] ? -q2_ff : q2_ff;
         xd_ff <= (qp_ff[WW-1] ? -qp_ff : qp_ff) << 1;
         yn_ff <= qp_ff[WW-1] ? -qp_ff : qp_ff;
         yd_ff <= lpd_ff[WW-1] ? -lpd_ff : lpd_ff;
         wv_ff <= w2_ff << Up;
      end
   end

   // Square root: one result bit per stage, with 63 squaring steps done
   // incrementally (r^2 updated by adds); the divider operands wait in a
   // delay line of the same depth.
   logic [OutWidth-1:0] sq_r [SqSteps+1];
   logic [WW-1:0] sq_r2 [SqSteps+1];
   logic [WW-1:0] sq_v [SqSteps+1];
   side_type sq_s [SqSteps+1];
   assign sq_r[0] = '0;
   assign sq_r2[0] = '0;
   assign sq_v[0] = wv_ff;
   assign sq_s[0] = s4_ff;
   for (genvar k = 0; k < SqSteps; k++) begin : g_sq
      localparam int unsigned B = SqSteps - 1 - k;
      logic [WW-1:0] cand2;
      assign cand2 = sq_r2[k] + ({64'd0, sq_r[k]} << (B + 1)) + (WW'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_r[k+1] <= cand2 <= sq_v[k] ? sq_r[k] | (OutWidth'(1) << B) : sq_r[k];
            sq_r2[k+1] <= cand2 <= sq_v[k] ? cand2 : sq_r2[k];
            sq_v[k+1] <= sq_v[k];
            sq_s[k+1] <= sq_s[k];
         end
      end
   end
   side_type side_tag;
   always_comb begin
      side_tag = sq_s[SqSteps];
      side_tag.w = sq_r[SqSteps];
   end

   // Side data runs through the x divider's tag; the y divider carries none.
   logic xd_vld, yd_vld, x_ovf, y_ovf;
   logic [OutWidth-1:0] x_q, y_q;
   side_type side_out;
   logic [WW-1:0] yn_d [SqSteps+1], yd_d [SqSteps+1], xn_d [SqSteps+1], xd_d [SqSteps+1];
   logic vq [SqSteps+1];
   assign yn_d[0] = yn_ff; assign yd_d[0] = yd_ff;
   assign xn_d[0] = xn_ff; assign xd_d[0] = xd_ff;
   assign vq[0] = v4_ff;
   for (genvar k = 0; k < SqSteps; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) vq[k+1] <= 1'b0;
         else if (advance) vq[k+1] <= vq[k];
         if (advance) begin
            yn_d[k+1] <= yn_d[k]; yd_d[k+1] <= yd_d[k];
            xn_d[k+1] <= xn_d[k]; xd_d[k+1] <= xd_d[k];
         end
      end
   end

   dek_div #(.Steps(DivSteps), .tag_type(side_type)) u_xdiv (
      .clock, .reset, .advance, .in_valid(vq[SqSteps]),
      .in_num(xn_d[SqSteps]), .in_den(xd_d[SqSteps]), .in_tag(side_tag),
      .out_valid(xd_vld), .out_quot(x_q), .out_ovf(x_ovf), .out_tag(side_out));
   dek_div #(.Steps(DivSteps), .tag_type(logic)) u_ydiv (
      .clock, .reset, .advance, .in_valid(vq[SqSteps]),
      .in_num(yn_d[SqSteps]), .in_den(yd_d[SqSteps]), .in_tag(1'b0),
      .out_valid(yd_vld), .out_quot(y_q), .out_ovf(y_ovf), .out_tag());

   function automatic logic [OutWidth:0] sgn_out(input logic [OutWidth-1:0] q,
      input logic ovf, input logic neg);
      logic [OutWidth-1:0] mn;
      mn = {1'b1, {(OutWidth-1){1'b0}}};
      if (neg) begin
         if (ovf || q > mn) return {1'b1, mn};
         return {1'b0, -q};
      end
      if (ovf || q > mn - 1) return {1'b1, mn - 1};
      return {1'b0, q};
   endfunction

   // Final stage: signs, saturation, output register.
   logic [OutWidth:0] xr, yr;
   rsp_type out_in;
   always_comb begin
      xr = sgn_out(x_q, x_ovf, side_out.xneg);
      yr = sgn_out(y_q, y_ovf, side_out.yneg);
      out_in.q_squared = side_out.q2;
      out_in.bjorken_x = side_out.xz ? '0 : xr[OutWidth-1:0];
      out_in.inelasticity = side_out.yz ? '0 : yr[OutWidth-1:0];
      out_in.hadronic_mass = side_out.wn ? '0
         : (side_out.wsat ? {MassWidth{1'b1}} : side_out.w[MassWidth-1:0]);
      out_in.x_denominator_zero = side_out.xz;
      out_in.w_nonphysical = side_out.wn;
      out_in.y_denominator_zero = side_out.yz;
      out_in.saturated = side_out.q2sat || (!side_out.xz && xr[OutWidth])
         || (!side_out.yz && yr[OutWidth]) || (!side_out.wn && side_out.wsat);
   end
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= xd_vld;
      if (advance) out_ff <= out_in;
   end
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.data = out_ff;

   `ASSERT_IMPLIES(a_div_align, clock, reset, 1'b1, xd_vld == yd_vld)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_q_squared))
   `ASSERT_IMPLIES(a_xz_zero, clock, reset, rsp_valid && rsp_x_denominator_zero,
      rsp_bjorken_x == '0)
endmodule
